// ===== rtl/keyed_state_table_upsert_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Keyed state table upsert unit: assertion macros
// Concurrent assertion helpers; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef KEYED_STATE_TABLE_UPSERT_UNIT_MACROS_SVH
`define KEYED_STATE_TABLE_UPSERT_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define KSTU_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define KSTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define KSTU_ASSERT_HOLDS(label, ante, cons)
`define KSTU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/kstu_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed state table upsert package
// Request/response types, request and status codes, register map.
// ----------------------------------------------------------------------------
package kstu_pkg;

    localparam int KEY_W   = 32;
    localparam int STATE_W = 4;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    typedef enum logic [1:0] {
        REQ_UPSERT = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_type_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_INIT = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // word index of the enable register
    localparam logic [ADDR_W-3:0] REG_ENABLED = '0;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [KEY_W-1:0]   key_id;
        logic [STATE_W-1:0] set_code;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               hit;
        logic [STATE_W-1:0] state_out;
    } rsp_t;

endpackage

// ===== rtl/kstu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kstu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/keyed_state_table_upsert_unit.sv =====
// ----------------------------------------------------------------------------
// Keyed state table upsert unit
// Table of TABLE_ENTRIES keys with a lifecycle state each; upsert, query, clear.
// ----------------------------------------------------------------------------
// One request at a time. Upsert and query requests scan the whole table through
// the single RAM read port, one entry per cycle, with one shared key compare,
// and a clear request sweeps the RAM one entry per cycle. Requests while
// disabled, and unused request types, go to the response without a table pass.
// After reset the table is cleared by a pass over every entry during which
// req_stall is high; APB writes are taken throughout. The response register
// lets the next request be accepted while a response is still stalled.
`include "keyed_state_table_upsert_unit_macros.svh"

module keyed_state_table_upsert_unit
    import kstu_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int STATE_BITS    = 4
) (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req,

    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_t              rsp
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int ENTRY_W = 1 + KEY_W + STATE_BITS;
    localparam int CW      = (STATE_BITS < STATE_W) ? STATE_BITS : STATE_W;

    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(TABLE_ENTRIES - 1);

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_IDLE = 6'b000010,
        S_SCAN = 6'b000100,
        S_UPD  = 6'b001000,
        S_CLR  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                  match_found_reg, match_found_next;
    logic [IDX_W-1:0]      match_idx_reg, match_idx_next;
    logic [STATE_BITS-1:0] match_state_reg, match_state_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    req_t                  req_reg, req_next;
    rsp_t                  res_reg, res_next;
    rsp_t                  rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  enabled_reg;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic                  rd_valid;
    logic [KEY_W-1:0]      rd_key;
    logic [STATE_BITS-1:0] rd_state;
    logic                  key_eq;
    logic [STATE_BITS-1:0] wr_state;
    logic                  cfg_wr;
    logic                  scan_done;

    kstu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[ADDR_W-1:2] == REG_ENABLED) ? DATA_W'(enabled_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
        end
        else if (cfg_wr && (paddr[ADDR_W-1:2] == REG_ENABLED))
        begin
            enabled_reg <= pwdata[0];
        end
    end

    assign rd_valid  = ram_rdata[ENTRY_W-1];
    assign rd_key    = ram_rdata[STATE_BITS +: KEY_W];
    assign rd_state  = ram_rdata[STATE_BITS-1:0];
    assign key_eq    = (rd_key == req_reg.key_id);
    assign wr_state  = STATE_BITS'(req_reg.set_code[CW-1:0]);
    assign scan_done = (cnt_reg == N_CNT) && !pend_reg;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pend_next        = 1'b0;
        pend_idx_next    = pend_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_state_next = match_state_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        req_next         = req_reg;
        res_next         = res_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        ram_we           = 1'b0;
        ram_waddr        = cnt_reg[IDX_W-1:0];
        ram_wdata        = '0;
        ram_raddr        = cnt_reg[IDX_W-1:0];

        unique case (state_reg)
            S_INIT:
            begin
                ram_we = 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next         = req;
                    cnt_next         = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    res_next         = '0;
                    if (!enabled_reg)
                    begin
                        res_next.status = ST_NOT_INIT;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        unique case (req.req_type)
                            REQ_UPSERT: state_next = S_SCAN;
                            REQ_QUERY:  state_next = S_SCAN;
                            REQ_CLEAR:  state_next = S_CLR;
                            default:    state_next = S_DONE;
                        endcase
                    end
                end
            end
            S_SCAN:
            begin
                if (cnt_reg != N_CNT)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    if (rd_valid && key_eq && !match_found_reg)
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = pend_idx_reg;
                        match_state_next = rd_state;
                    end
                    if (!rd_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pend_idx_reg;
                    end
                end
                if (scan_done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                ram_wdata = {1'b1, req_reg.key_id, wr_state};
                if (req_reg.req_type == REQ_QUERY)
                begin
                    res_next.hit       = match_found_reg;
                    res_next.state_out = match_found_reg ?
                                         STATE_W'(match_state_reg[CW-1:0]) : '0;
                end
                else if (match_found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = match_idx_reg;
                end
                else if (free_found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = free_idx_reg;
                end
                else
                begin
                    res_next.status = ST_FULL;
                end
                state_next = S_DONE;
            end
            S_CLR:
            begin
                ram_we = 1'b1;
                if (cnt_reg == LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            cnt_reg         <= '0;
            pend_reg        <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            pend_reg        <= pend_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg    <= pend_idx_next;
        match_idx_reg   <= match_idx_next;
        match_state_reg <= match_state_next;
        free_idx_reg    <= free_idx_next;
        req_reg         <= req_next;
        res_reg         <= res_next;
        rsp_reg         <= rsp_next;
    end

    `KSTU_ASSERT_HOLDS(a_scan_bound, state_reg == S_SCAN, cnt_reg <= N_CNT)
    `KSTU_ASSERT_HOLDS(a_hit_ok, rsp_valid_reg && rsp_reg.hit, rsp_reg.status == ST_OK)
    `KSTU_ASSERT_HOLDS(a_ram_wr_state, ram_we, (state_reg & (S_INIT | S_CLR | S_UPD)) != '0)
    `KSTU_ASSERT_HOLDS(a_rsp_src, $rose(rsp_valid_reg), $past(state_reg) == S_DONE)
    `KSTU_ASSERT_NEXT(a_scan_to_upd, state_reg == S_SCAN && scan_done, state_reg == S_UPD)

endmodule
